### rtl/core/ptq_pkg.sv
package ptq_pkg;

    localparam int HEAP_DEPTH = 64;
    localparam int FILL_W     = $clog2(HEAP_DEPTH + 1);
    localparam int FIRE_CAP   = 64;

    // result kinds
    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_REFUSE = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;

    // command codes
    localparam logic CMD_SCHED   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] period;
        logic [7:0]  handler;
        logic [31:0] word;
        logic [31:0] id;
    } entry_t;

    typedef struct packed {
        logic ins;
        logic pop;
    } cell_op_t;

    // strict order: due first, then id
    function automatic logic earlier(input entry_t a, input entry_t b);
        if (a.due != b.due)
            return a.due < b.due;
        return a.id < b.id;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

### rtl/core/periodic_timer_heap_queue.sv
// Periodic timer queue. Timers are kept sorted by (due, id) in a row of cells;
// the head cell always holds the next timer to expire.
// Input stream s_axis: tuser is the command (schedule or advance), tdata the
// schedule fields and the new time. Output stream m_axis: tuser is the result
// kind, tlast marks the final result of one input transfer.
// Schedule: one result, registered in S_INS for an assigned id, or in S_SCHED
// when refused because all 64 cells are full; S_SCHED waits for a free output register.
// Advance: each pop is made in S_CHECK once the output register is free; a
// periodic timer with a nonzero handler is re-armed through S_RA1, S_RA2 and S_INS;
// up to max_fires_per_advance pops. An advance that fires nothing gives no
// result. The next input transfer is taken once the current one is finished.
// Each result is held in an output register; a stalled receiver holds the
// block at the next result it wants to send, nothing is lost.
// Reset empties the queue, sets the id counter to 1, the time to 0 and the
// fire limit to 64. cfg_wdata is written whenever cfg_we is high; the user must
// raise cfg_we only while the block is idle, which the block does not enforce.
module periodic_timer_heap_queue
    import ptq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,      // max_fires_per_advance
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,   // delay_ticks, period_ticks, handler_tag, user_word, new_time
    input  logic         s_axis_tuser,   // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // timer_id, fired_handler, fired_word
    output logic [1:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCHED = 6'b000010,
        S_INS   = 6'b000100,
        S_CHECK = 6'b001000,
        S_RA1   = 6'b010000,
        S_RA2   = 6'b100000
    } state_t;

    state_t            state_reg;
    logic [6:0]        limit_cfg_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [31:0]       id_ctr_reg;
    logic [31:0]       now_reg;
    logic [6:0]        pops_reg;
    logic              sched_reg;
    entry_t            cur_reg;
    logic [31:0]       delay_reg;

    // pending fired result, held back to know whether it is the last
    logic              pend_valid_reg;
    logic [31:0]       pend_id_reg;
    logic [7:0]        pend_handler_reg;
    logic [31:0]       pend_word_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [31:0]       out_id_reg;
    logic [7:0]        out_handler_reg;
    logic [31:0]       out_word_reg;
    logic              out_last_reg;

    entry_t            head;
    cell_op_t          op;
    logic [6:0]        limit;
    logic              elig;
    logic              accept;

    // clamp fire limit to 1..FIRE_CAP
    always_comb
    begin
        if (limit_cfg_reg == 7'd0)
            limit = 7'd1;
        else if (limit_cfg_reg > 7'(FIRE_CAP))
            limit = 7'(FIRE_CAP);
        else
            limit = limit_cfg_reg;
    end

    assign elig   = (fill_reg != '0) && (head.due <= now_reg) && (pops_reg < limit);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign op.ins = (state_reg == S_INS);
    assign op.pop = (state_reg == S_CHECK) && !out_valid_reg && elig;

    ptq_chain u_chain (
        .clk     (clk),
        .op      (op),
        .fill    (fill_reg),
        .new_ent (cur_reg),
        .head    (head)
    );

    // control and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_cfg_reg  <= 7'(FIRE_CAP);
            fill_reg       <= '0;
            id_ctr_reg     <= 32'd1;
            now_reg        <= '0;
            pops_reg       <= '0;
            sched_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_cfg_reg <= cfg_wdata;
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_axis_tuser == CMD_ADVANCE)
                        begin
                            now_reg   <= s_axis_tdata[135:104];
                            pops_reg  <= '0;
                            sched_reg <= 1'b0;
                            state_reg <= S_CHECK;
                        end
                        else
                        begin
                            sched_reg <= 1'b1;
                            state_reg <= S_SCHED;
                        end
                    end
                end
                S_SCHED:
                begin
                    if (!out_valid_reg)
                    begin
                        if (fill_reg == FILL_W'(HEAP_DEPTH))
                        begin
                            out_valid_reg   <= 1'b1;
                            out_kind_reg    <= KIND_REFUSE;
                            out_id_reg      <= '0;
                            out_handler_reg <= '0;
                            out_word_reg    <= '0;
                            out_last_reg    <= 1'b1;
                            state_reg       <= S_IDLE;
                        end
                        else
                        begin
                            id_ctr_reg <= (id_ctr_reg == 32'hFFFF_FFFF) ? 32'd1
                                                                         : id_ctr_reg + 32'd1;
                            state_reg  <= S_INS;
                        end
                    end
                end
                S_INS:
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                    if (sched_reg)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_kind_reg    <= KIND_SCHED;
                        out_id_reg      <= cur_reg.id;
                        out_handler_reg <= '0;
                        out_word_reg    <= '0;
                        out_last_reg    <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (!out_valid_reg)
                    begin
                        if (elig)
                        begin
                            fill_reg <= fill_reg - FILL_W'(1);
                            pops_reg <= pops_reg + 7'd1;
                            if (head.handler != 8'd0)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_reg   <= 1'b1;
                                    out_kind_reg    <= KIND_FIRED;
                                    out_id_reg      <= pend_id_reg;
                                    out_handler_reg <= pend_handler_reg;
                                    out_word_reg    <= pend_word_reg;
                                    out_last_reg    <= 1'b0;
                                end
                                pend_valid_reg <= 1'b1;
                                if (head.period != 32'd0)
                                    state_reg <= S_RA1;
                            end
                        end
                        else
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg   <= 1'b1;
                                out_kind_reg    <= KIND_FIRED;
                                out_id_reg      <= pend_id_reg;
                                out_handler_reg <= pend_handler_reg;
                                out_word_reg    <= pend_word_reg;
                                out_last_reg    <= 1'b1;
                                pend_valid_reg  <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RA1:
                begin
                    state_reg <= S_RA2;
                end
                S_RA2:
                begin
                    state_reg <= S_INS;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload of the entry being scheduled or re-armed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    delay_reg      <= s_axis_tdata[31:0];
                    cur_reg.period <= s_axis_tdata[63:32];
                    cur_reg.handler <= s_axis_tdata[71:64];
                    cur_reg.word   <= s_axis_tdata[103:72];
                end
            end
            S_SCHED:
            begin
                cur_reg.due <= sat_add(now_reg, delay_reg);
                cur_reg.id  <= id_ctr_reg;
            end
            S_CHECK:
            begin
                if (!out_valid_reg && elig && head.handler != 8'd0)
                begin
                    cur_reg          <= head;
                    pend_id_reg      <= head.id;
                    pend_handler_reg <= head.handler;
                    pend_word_reg    <= head.word;
                end
            end
            S_RA1:
            begin
                cur_reg.due <= sat_add(cur_reg.due, cur_reg.period);
            end
            S_RA2:
            begin
                if (cur_reg.due <= now_reg)
                    cur_reg.due <= sat_add(now_reg, cur_reg.period);
            end
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_word_reg, out_handler_reg, out_id_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

### rtl/core/ptq_cell.sv
module ptq_cell
    import ptq_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  logic     occ,
    input  entry_t   new_ent,
    input  entry_t   left_ent,
    input  logic     left_less,
    input  entry_t   right_ent,
    output entry_t   ent,
    output logic     less
);

    entry_t ent_reg;

    // this cell sorts ahead of the incoming entry
    assign less = occ && earlier(ent_reg, new_ent);
    assign ent  = ent_reg;

    // insert shifts toward the tail, pop shifts toward the head
    always_ff @(posedge clk)
    begin
        if (op.ins && !less)
        begin
            ent_reg <= left_less ? new_ent : left_ent;
        end
        else if (op.pop)
        begin
            ent_reg <= right_ent;
        end
    end

endmodule

### rtl/core/ptq_chain.sv
module ptq_chain
    import ptq_pkg::*;
(
    input  logic              clk,
    input  cell_op_t          op,
    input  logic [FILL_W-1:0] fill,
    input  entry_t            new_ent,
    output entry_t            head
);

    entry_t ents [HEAP_DEPTH];
    logic   lss  [HEAP_DEPTH];

    genvar i;
    generate
        for (i = 0; i < HEAP_DEPTH; i++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_l;
            if (i == 0)
            begin : g_first
                assign left_e = new_ent;
                assign left_l = 1'b1;
            end
            else
            begin : g_mid
                assign left_e = ents[i-1];
                assign left_l = lss[i-1];
            end
            if (i == HEAP_DEPTH - 1)
            begin : g_tail
                assign right_e = ents[i];
            end
            else
            begin : g_body
                assign right_e = ents[i+1];
            end
            ptq_cell u_cell (
                .clk       (clk),
                .op        (op),
                .occ       (FILL_W'(i) < fill),
                .new_ent   (new_ent),
                .left_ent  (left_e),
                .left_less (left_l),
                .right_ent (right_e),
                .ent       (ents[i]),
                .less      (lss[i])
            );
        end
    endgenerate

    assign head = ents[0];

endmodule

### sim/periodic_timer_heap_queue_test.sv
module periodic_timer_heap_queue_test;
    import ptq_pkg::*;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [7:0]  handler;
        logic [31:0] word;
        logic        last;
    } result_t;

    typedef struct {
        logic        cmd;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  handler;
        logic [31:0] word;
        logic [31:0] ntime;
        bit          chk;
        logic [1:0]  ekind;
        logic [31:0] eid;
    } stim_t;

    localparam int N_DIR = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE = 300;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [6:0]   cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    // predictor state
    entry_t      armed_timers[$];
    result_t     expected_results[$];
    logic [31:0] next_id = 32'd1;
    logic [31:0] now_ticks = '0;
    logic [6:0]  fire_limit_reg = 7'd64;

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_off = 1'b0;
    int quiet_cycles = 0;

    stim_t directed [N_DIR] = '{
        '{CMD_SCHED, 0, 0, 8'h01, 0, 0, 1, KIND_SCHED, 1},
        '{CMD_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 0, 1, KIND_SCHED, 2},
        '{CMD_SCHED, 5, 3, 8'h00, 32'h1234, 0, 1, KIND_SCHED, 3},
        '{CMD_SCHED, 10, 7, 8'h80, 32'hA5A5_A5A5, 0, 1, KIND_SCHED, 4},
        '{CMD_ADVANCE, 0, 0, 0, 0, 0, 1, KIND_FIRED, 1},
        '{CMD_ADVANCE, 0, 0, 0, 0, 20, 0, 0, 0},
        '{CMD_ADVANCE, 0, 0, 0, 0, 10, 0, 0, 0},
        '{CMD_SCHED, 0, 0, 8'h7F, 32'h5A5A_5A5A, 0, 1, KIND_SCHED, 5},
        '{CMD_ADVANCE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0},
        '{CMD_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0},
        '{CMD_SCHED, 1, 1, 8'h02, 0, 0, 1, KIND_SCHED, 6},
        '{CMD_ADVANCE, 0, 0, 0, 0, 3, 0, 0, 0}
    };

    periodic_timer_heap_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // index of the next timer to expire: smallest due, then smallest id
    function automatic int soonest_timer();
        int best;
        best = 0;
        for (int i = 1; i < armed_timers.size(); i++)
            if (armed_timers[i].due < armed_timers[best].due ||
                (armed_timers[i].due == armed_timers[best].due &&
                 armed_timers[i].id < armed_timers[best].id))
                best = i;
        return best;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // work out the results of one accepted transfer
    task automatic predict_timer_results(input stim_t s);
        entry_t  t;
        result_t r;
        int      limit;
        int      pops;
        int      first;
        int      b;
        first = expected_results.size();
        if (s.cmd == CMD_SCHED) begin
            r = '{KIND_SCHED, 0, 0, 0, 1'b1};
            if (armed_timers.size() >= HEAP_DEPTH) begin
                r.kind = KIND_REFUSE;
            end
            else begin
                r.id = next_id;
                t = '{add_clamped(now_ticks, s.delay), s.period, s.handler, s.word, next_id};
                armed_timers.push_back(t);
                next_id = next_id + 1;
                if (next_id == 0)
                    next_id = 1;
            end
            expected_results.push_back(r);
        end
        else begin
            limit = fire_limit_reg;
            if (limit == 0)
                limit = 1;
            if (limit > FIRE_CAP)
                limit = FIRE_CAP;
            now_ticks = s.ntime;
            pops = 0;
            while (armed_timers.size() > 0 && pops < limit) begin
                b = soonest_timer();
                t = armed_timers[b];
                if (t.due > now_ticks)
                    break;
                armed_timers.delete(b);
                pops++;
                if (t.handler != 0) begin
                    expected_results.push_back('{KIND_FIRED, t.id, t.handler, t.word, 1'b0});
                    if (t.period != 0) begin
                        t.due = add_clamped(t.due, t.period);
                        if (t.due <= now_ticks)
                            t.due = add_clamped(now_ticks, t.period);
                        armed_timers.push_back(t);
                    end
                end
            end
            if (expected_results.size() > first)
                expected_results[expected_results.size() - 1].last = 1'b1;
        end
        if (s.chk) begin
            if (expected_results.size() <= first)
                report_mismatch("typed result missing", 0, 1);
            else begin
                if (expected_results[first].kind != s.ekind)
                    report_mismatch("typed kind", expected_results[first].kind, s.ekind);
                if (expected_results[first].id != s.eid)
                    report_mismatch("typed id", expected_results[first].id, s.eid);
            end
        end
    endtask

    // offer one item, sometimes after a random gap, and wait for its transfer
    task automatic send_item(input stim_t s);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= s.cmd;
        s_axis_tdata  <= {s.ntime, s.word, s.handler, s.period, s.delay};
        do @(posedge clk); while (!s_axis_tready);
        predict_timer_results(s);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (expected_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_fire_limit(input logic [6:0] v);
        go_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        fire_limit_reg = v;
    endtask

    function automatic logic [31:0] rand_ticks();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(50);
            default: return $urandom_range(60);
        endcase
    endfunction

    function automatic stim_t rand_item();
        stim_t s;
        s = '{default: '0};
        s.cmd     = ($urandom_range(99) < 55) ? CMD_SCHED : CMD_ADVANCE;
        s.delay   = rand_ticks();
        s.period  = ($urandom_range(2) == 0) ? 32'd0 : rand_ticks();
        s.handler = ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        s.word    = $urandom;
        case ($urandom_range(9))
            0: s.ntime = $urandom;
            1: s.ntime = 32'hFFFF_FFFF;
            2: s.ntime = now_ticks - $urandom_range(20);
            default: s.ntime = now_ticks + $urandom_range(40);
        endcase
        return s;
    endfunction

    // receiver with random stalls and an optional long hold-off
    always @(posedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    // compare every result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t w;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", m_axis_tdata[31:0], 0);
            else begin
                w = expected_results.pop_front();
                if (m_axis_tuser != w.kind)
                    report_mismatch("kind", m_axis_tuser, w.kind);
                if (m_axis_tdata[31:0] != w.id)
                    report_mismatch("timer_id", m_axis_tdata[31:0], w.id);
                if (m_axis_tdata[39:32] != w.handler)
                    report_mismatch("handler", m_axis_tdata[39:32], w.handler);
                if (m_axis_tdata[71:40] != w.word)
                    report_mismatch("word", m_axis_tdata[71:40], w.word);
                if (m_axis_tlast != w.last)
                    report_mismatch("last", m_axis_tlast, w.last);
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("periodic_timer_heap_queue_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        stim_t s;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIR; i++)
            send_item(directed[i]);

        // fill past capacity while the receiver holds off
        write_fire_limit(7'd1);
        send_idle_pct = 0;
        hold_off <= 1'b1;
        fork
            begin
                repeat (800) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        for (int i = 0; i < HEAP_DEPTH + 2; i++) begin
            s = rand_item();
            s.cmd = CMD_SCHED;
            s.delay = $urandom_range(100);
            s.period = 0;
            send_item(s);
        end
        s = '{default: '0};
        s.cmd = CMD_ADVANCE;
        s.ntime = 32'd200;
        send_item(s);

        // drain at the largest limit, then wind time back
        write_fire_limit(7'd127);
        send_item(s);
        send_item(s);
        s.ntime = 0;
        send_item(s);

        // random traffic across limit settings and idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_fire_limit(7'd64);
                1: write_fire_limit(7'd0);
                2: write_fire_limit(7'd3);
                default: write_fire_limit(7'd127);
            endcase
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 74) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 74) : 0;
            if (ph == 1)
                recv_stall_pct = 0;
            for (int i = 0; i < 5; i++)
                send_item(rand_item());
        end

        s_axis_tvalid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("periodic_timer_heap_queue_test: done, clean");
        else
            $display("periodic_timer_heap_queue_test: done, errors");
        $finish;
    end

endmodule

### periodic_timer_heap_queue.f
rtl/core/ptq_pkg.sv
rtl/core/ptq_cell.sv
rtl/core/ptq_chain.sv
rtl/core/periodic_timer_heap_queue.sv
sim/periodic_timer_heap_queue_test.sv
